// ===== rtl/core/gss_pkg.sv =====
// gss_pkg: shared types and constants for the gini split selector
// no dependencies; imported by every module in rtl/core
package gss_pkg;
  localparam int MaxLabels    = 4;
  localparam int CountBits    = 24;
  localparam int FeatureCount = 8;
  localparam int LaneBits     = (MaxLabels > 4) ? 3 : ((MaxLabels > 2) ? 2 : 1);
  localparam int TotalBits    = CountBits + LaneBits + 1;
  localparam int PreShift     = (TotalBits > 27) ? TotalBits - 27 : 0;
  localparam int CBits        = CountBits - PreShift;
  // side total / square sum widths
  localparam int TBits        = CBits + LaneBits;
  localparam int SBits        = 2 * CBits + LaneBits;
  localparam int AllBits      = TBits + 1;
  localparam int NumBits      = 2 * TBits;
  localparam int DenBits      = TBits + AllBits;
  localparam int GiniBits     = 16;
  localparam int FracSteps    = 16;
  localparam int StepBits     = 5;
  localparam int LcBits       = 3;
  localparam int FeatBits     = 3;
  localparam int ThrBits      = 16;
  localparam int AddrBits     = 2;
  localparam logic [AddrBits-1:0] RegLabelCount = 2'd0;
  localparam logic [LcBits-1:0]   LabelCountRst = 3'd3;
  localparam logic [GiniBits:0]   GiniNone = 17'h10000;

  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQR, ST_MUL, ST_DIV, ST_DONE
  } state_t;

  // side result: side total and sum of squares
  typedef struct packed {
    logic [TBits-1:0] tot;
    logic [SBits-1:0] sq;
  } side_t;
endpackage

// ===== rtl/core/gini_split_selector_core.sv =====
// gini_split_selector_core: top level of the gini split selector
// depends on gss_pkg, gss_lane, gss_merge, gss_frac
//
// channel | dir | ports
// in      | in  | in_valid/in_ready, counts, feature, threshold, last
// out     | out | out_valid/out_ready, gini, kept best
// cfg     | in  | apb psel/penable/pwrite/paddr/pwdata/prdata/pready
// one candidate passes through accept, lane squares and merge, the shared divider
// (operand multiply, start, 16 steps, add) that computes the two side shares one
// after the other, and the result register.
// rst_n is synchronous; it clears the kept best and label_count to 3.
// the result waits in the output register; a new transaction is taken once
// the previous result has been taken.
module gini_split_selector_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gss_pkg::count_t              in_right_count_0,
  input  gss_pkg::count_t              in_right_count_1,
  input  gss_pkg::count_t              in_right_count_2,
  input  gss_pkg::count_t              in_right_count_3,
  input  gss_pkg::count_t              in_left_count_0,
  input  gss_pkg::count_t              in_left_count_1,
  input  gss_pkg::count_t              in_left_count_2,
  input  gss_pkg::count_t              in_left_count_3,
  input  logic [2:0]                   in_feature_index,
  input  logic signed [15:0]           in_threshold_value,
  input  logic                         in_last_candidate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_candidate_gini,
  output logic [16:0]                  out_best_gini,
  output logic [2:0]                   out_best_feature,
  output logic signed [15:0]           out_best_threshold,
  output logic                         out_best_found,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gss_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import gss_pkg::*;

  state_t state_r, state_nxt;
  logic [StepBits-1:0] cnt_r, cnt_nxt;
  logic side_r, side_nxt;
  logic [LcBits-1:0] label_count_r;
  logic [FeatBits-1:0] feat_r;
  logic [ThrBits-1:0] thr_r;
  logic last_r;
  logic [GiniBits:0] kept_gini_r;
  logic [FeatBits-1:0] kept_feature_r;
  logic [ThrBits-1:0] kept_threshold_r;
  logic kept_valid_r;
  logic [GiniBits:0] acc_r;
  logic load, div_start, acc_add, finish;
  logic [MaxLabels-1:0] lane_used;
  count_t right_in [MaxLabels];
  count_t left_in [MaxLabels];
  logic [MaxLabels-1:0][CBits-1:0] rval, lval;
  logic [MaxLabels-1:0][2*CBits-1:0] rsq, lsq;
  side_t rside, lside;
  logic [AllBits-1:0] tall;
  logic [NumBits-1:0] num_r;
  logic [DenBits-1:0] den_r;
  logic [GiniBits:0] q;
  logic [GiniBits+1:0] sum;
  logic [GiniBits-1:0] gini;

  assign pready = 1'b1;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign load = in_valid && in_ready;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_count_r <= LabelCountRst;
    end else if (psel && penable && pwrite && paddr == RegLabelCount) begin
      label_count_r <= pwdata[LcBits-1:0];
    end
  end
  assign prdata = (paddr == RegLabelCount) ? 32'(label_count_r) : '0;

  // lane enables
  always_comb begin
    for (int i = 0; i < MaxLabels; i++) begin
      lane_used[i] = (32'(label_count_r) > i);
    end
  end

  assign right_in = '{in_right_count_0, in_right_count_1, in_right_count_2, in_right_count_3};
  assign left_in  = '{in_left_count_0, in_left_count_1, in_left_count_2, in_left_count_3};

  // lanes
  for (genvar g = 0; g < MaxLabels; g++) begin : g_lane
    gss_lane u_rl (.clk, .load, .used(lane_used[g]), .count(right_in[g]),
                   .val_r(rval[g]), .sqr_r(rsq[g]));
    gss_lane u_ll (.clk, .load, .used(lane_used[g]), .count(left_in[g]),
                   .val_r(lval[g]), .sqr_r(lsq[g]));
  end

  gss_merge u_rm (.clk, .vals(rval), .sqrs(rsq), .side_r(rside));
  gss_merge u_lm (.clk, .vals(lval), .sqrs(lsq), .side_r(lside));

  assign tall = AllBits'(rside.tot) + AllBits'(lside.tot);

  // share operands for the side in turn
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      if (!side_r) begin
        num_r <= rside.tot * rside.tot - NumBits'(rside.sq);
        den_r <= rside.tot * tall;
      end else begin
        num_r <= lside.tot * lside.tot - NumBits'(lside.sq);
        den_r <= lside.tot * tall;
      end
    end
  end

  gss_frac u_div (.clk, .start(div_start), .num(num_r), .den(den_r), .q_r(q));

  // running sum of shares, saturated for the result
  assign sum = (GiniBits+2)'(acc_r) + (GiniBits+2)'(q);
  assign gini = (sum[GiniBits+1] || sum[GiniBits]) ? '1 : sum[GiniBits-1:0];

  // control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    side_nxt = side_r;
    div_start = 1'b0;
    acc_add = 1'b0;
    finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_SQR;
          cnt_nxt = '0;
          side_nxt = 1'b0;
        end
      end
      ST_SQR: begin
        // lane square, then merge
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == StepBits'(1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        div_start = (cnt_r == '0);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == StepBits'(FracSteps + 1)) begin
          acc_add = 1'b1;
          if (side_r) begin
            state_nxt = ST_DONE;
            finish = 1'b1;
          end else begin
            side_nxt = 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      side_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      side_r <= side_nxt;
    end
  end

  // clear and accumulate shares; capture candidate fields on accept
  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= '0;
      feat_r <= in_feature_index;
      thr_r <= in_threshold_value;
      last_r <= in_last_candidate;
    end else if (acc_add) begin
      acc_r <= sum[GiniBits+1] ? GiniNone : sum[GiniBits:0];
    end
  end

  // result register and kept best
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_gini_r <= GiniNone;
      kept_feature_r <= '0;
      kept_threshold_r <= '0;
      kept_valid_r <= 1'b0;
    end else if (finish) begin
      if ((GiniBits+1)'(gini) < kept_gini_r && 32'(feat_r) < FeatureCount) begin
        out_best_gini <= (GiniBits+1)'(gini);
        out_best_feature <= feat_r;
        out_best_threshold <= thr_r;
        out_best_found <= 1'b1;
        kept_gini_r <= (GiniBits+1)'(gini);
        kept_feature_r <= feat_r;
        kept_threshold_r <= thr_r;
        kept_valid_r <= 1'b1;
      end else begin
        out_best_gini <= kept_gini_r;
        out_best_feature <= kept_feature_r;
        out_best_threshold <= kept_threshold_r;
        out_best_found <= kept_valid_r;
      end
      out_candidate_gini <= gini;
    end else if (out_valid && out_ready && last_r) begin
      kept_gini_r <= GiniNone;
      kept_feature_r <= '0;
      kept_threshold_r <= '0;
      kept_valid_r <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_kept_cons: assert property (@(posedge clk) disable iff (!rst_n)
    !kept_valid_r |-> kept_gini_r == GiniNone) else $error("kept state mismatch");
  a_done_next: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid) else $error("result lost");
`endif
endmodule

// ===== rtl/core/gss_lane.sv =====
// gss_lane: one label lane, registered masked count and its square
// depends on gss_pkg; one lane per label and side, merged by gss_merge
module gss_lane (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 used,
  input  gss_pkg::count_t      count,
  output logic [gss_pkg::CBits-1:0]     val_r,
  output logic [2*gss_pkg::CBits-1:0]   sqr_r
);
  import gss_pkg::*;
  logic [CBits-1:0] val_nxt;

  // masked and pre-shifted count
  assign val_nxt = used ? CBits'(count >> PreShift) : '0;

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= val_nxt;
    end
    sqr_r <= val_r * val_r;
  end
endmodule

// ===== rtl/core/gss_merge.sv =====
// gss_merge: adds lane results into side totals and square sums
// depends on gss_pkg
module gss_merge (
  input  logic                                                clk,
  input  logic [gss_pkg::MaxLabels-1:0][gss_pkg::CBits-1:0]   vals,
  input  logic [gss_pkg::MaxLabels-1:0][2*gss_pkg::CBits-1:0] sqrs,
  output gss_pkg::side_t                                      side_r
);
  import gss_pkg::*;
  side_t side_nxt;

  // sum over lanes
  always_comb begin
    side_nxt = '0;
    for (int i = 0; i < MaxLabels; i++) begin
      side_nxt.tot = side_nxt.tot + TBits'(vals[i]);
      side_nxt.sq  = side_nxt.sq + SBits'(sqrs[i]);
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
  end
endmodule

// ===== rtl/core/gss_frac.sv =====
// gss_frac: bit-serial restoring divider, floor(num*2^16/den)
// depends on gss_pkg; one step per cycle
module gss_frac (
  input  logic                           clk,
  input  logic                           start,
  input  logic [gss_pkg::NumBits-1:0]    num,
  input  logic [gss_pkg::DenBits-1:0]    den,
  output logic [gss_pkg::GiniBits:0]     q_r
);
  import gss_pkg::*;
  logic [DenBits:0]   rem_r;
  logic [DenBits-1:0] den_r;
  logic [DenBits:0]   sh;

  assign sh = {rem_r[DenBits-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= (DenBits+1)'(num);
      // zero denominator returns zero; num >= den returns one
      if (den == '0) begin
        q_r <= '0;
      end else if (DenBits'(num) >= den) begin
        q_r <= GiniNone;
      end else begin
        q_r <= '0;
      end
    end else if (!q_r[GiniBits] && den_r != '0) begin
      if (sh >= {1'b0, den_r}) begin
        rem_r <= sh - {1'b0, den_r};
        q_r   <= {q_r[GiniBits-1:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r   <= {q_r[GiniBits-1:0], 1'b0};
      end
    end
  end
endmodule
